// ===== src/lmps_pkg.sv =====
// shared types and constants for the linear model predictor and scorer
package lmps_pkg;

  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;
  localparam int CfgIdxW = 4;

  localparam logic [RegIdxW-1:0] RegIntercept = 3'd0;
  localparam logic [RegIdxW-1:0] RegWtSize    = 3'd1;
  localparam logic [RegIdxW-1:0] RegWtLoc     = 3'd2;
  localparam logic [RegIdxW-1:0] RegWtSec     = 3'd3;
  localparam logic [RegIdxW-1:0] RegWtGar     = 3'd4;
  localparam logic [RegIdxW-1:0] RegWtStorey  = 3'd5;
  localparam logic [RegIdxW-1:0] RegWtRooms   = 3'd6;
  localparam logic [RegIdxW-1:0] RegWtYear    = 3'd7;

  localparam logic signed [39:0] Pos40 = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] Neg40 = 40'sh80_0000_0000;
  localparam logic [38:0] Max39 = 39'h7F_FFFF_FFFF;
  localparam logic [55:0] Max56 = 56'hFF_FFFF_FFFF_FFFF;

  // controller to datapath commands
  typedef struct packed {
    logic       clr_acc;    // start a new prediction sum
    logic       mac;        // add one weighted term
    logic [2:0] term;       // which term to add
    logic       finish;     // saturate, score and accumulate
    logic       div_start;  // load the dividers
    logic       div_step;   // one quotient bit each
    logic       capture;    // load the output register
  } lmps_cmd_t;

  typedef struct packed {
    logic last;
  } lmps_sts_t;

endpackage

// ===== src/lmps_ctrl.sv =====
// controller state machine sequencing terms, scoring and division
module lmps_ctrl import lmps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  lmps_sts_t sts,
  output lmps_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_FIN, S_DIV, S_CAP} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] term_r, term_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.term  = term_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.clr_acc = 1'b1;
          term_nxt    = RegIntercept;
          state_nxt   = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        term_nxt = term_r + 3'd1;
        if (term_r == RegWtYear) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (sts.last) begin
          state_nxt = S_DIV;
          cnt_nxt   = 6'd0;
        end else begin
          state_nxt = S_CAP;
        end
      end
      S_DIV: begin
        if (cnt_r == 6'd0) cmd.div_start = 1'b1;
        else cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd56) state_nxt = S_CAP;
      end
      S_CAP: begin
        if (!ov_r || !out_stall) begin
          cmd.capture = 1'b1;
          ov_nxt      = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ov_r && !out_stall && !cmd.capture) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= 3'd0;
      cnt_r   <= 6'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ===== src/lmps_dp.sv =====
// datapath: coefficients, shared multiplier, scoring, accumulators, dividers
module lmps_dp import lmps_pkg::*; #(
  parameter longint MAX_ITEMS   = 65536,
  parameter longint ERROR_LIMIT = 2560000
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_idx,
  input  logic signed [39:0]        cfg_wdata,
  input  logic                      in_take,
  input  logic [23:0]               in_size,
  input  logic [7:0]                in_location,
  input  logic [7:0]                in_security,
  input  logic [7:0]                in_garage,
  input  logic [7:0]                in_storey,
  input  logic [7:0]                in_room_count,
  input  logic [11:0]               in_build_year,
  input  logic signed [39:0]        in_true_price,
  input  logic                      in_end_of_run,
  input  lmps_cmd_t                 cmd,
  output lmps_sts_t                 sts,
  output logic signed [39:0]        out_predicted_price,
  output logic [38:0]               out_abs_error,
  output logic                      out_within_limit,
  output logic                      out_run_done,
  output logic [38:0]               out_mean_error,
  output logic [16:0]               out_hit_total,
  output logic [16:0]               out_item_total,
  output logic [16:0]               out_accuracy_fraction
);

  localparam longint CapL = (MAX_ITEMS < 131071) ? MAX_ITEMS : 131071;
  localparam logic [16:0] Cap = 17'(CapL);
  localparam logic [38:0] Limit = 39'(ERROR_LIMIT);

  logic signed [39:0] regs_r [NumRegs];

  // captured request
  logic [23:0]        size_r;
  logic [7:0]         f_r [5];
  logic [11:0]        year_r;
  logic signed [39:0] truth_r;
  logic               last_r;

  // wide enough for the size term plus all the others at full scale
  logic signed [49:0] acc_r;
  logic signed [39:0] pred_r;
  logic [38:0]        err_r;
  logic               hit_r;
  logic [55:0]        esum_r;
  logic [16:0]        hits_r, items_r;
  logic [16:0]        fin_hits_r, fin_items_r;

  // restoring dividers, one quotient bit a cycle
  logic [55:0] mq_r;
  logic [16:0] mrem_r;
  logic [55:0] fq_r;
  logic [16:0] frem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) regs_r[i] <= '0;
    end else if (cfg_we && cfg_idx < CfgIdxW'(NumRegs)) begin
      regs_r[cfg_idx[RegIdxW-1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      size_r  <= in_size;
      f_r[0]  <= in_location;
      f_r[1]  <= in_security;
      f_r[2]  <= in_garage;
      f_r[3]  <= in_storey;
      f_r[4]  <= in_room_count;
      year_r  <= in_build_year;
      truth_r <= in_true_price;
      last_r  <= in_end_of_run;
    end
  end

  assign sts.last = last_r;

  // one product per cycle
  logic signed [39:0] coef;
  logic signed [24:0] feat;
  logic signed [64:0] prod;
  logic signed [49:0] term;
  always_comb begin
    coef = regs_r[cmd.term];
    feat = '0;
    case (cmd.term)
      RegWtSize:   feat = {1'b0, size_r};
      RegWtLoc:    feat = {17'd0, f_r[0]};
      RegWtSec:    feat = {17'd0, f_r[1]};
      RegWtGar:    feat = {17'd0, f_r[2]};
      RegWtStorey: feat = {17'd0, f_r[3]};
      RegWtRooms:  feat = {17'd0, f_r[4]};
      RegWtYear:   feat = {13'd0, year_r};
      default:     feat = 25'sd1;
    endcase
    prod = coef * feat;
    if (cmd.term == RegWtSize) term = 50'(prod >>> 16);
    else                       term = 50'(prod >>> 8);
  end

  // score
  logic signed [39:0] sat;
  logic signed [41:0] diff;
  logic [41:0]        mag;
  logic [38:0]        err;
  logic [56:0]        esum_add;
  always_comb begin
    if (acc_r > 50'(Pos40))      sat = Pos40;
    else if (acc_r < 50'(Neg40)) sat = Neg40;
    else                         sat = acc_r[39:0];
    diff = 42'(sat) - 42'(truth_r);
    mag  = diff[41] ? 42'(-diff) : diff;
    err  = (mag > 42'(Max39)) ? Max39 : mag[38:0];
    esum_add = {1'b0, esum_r} + 57'(err);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) acc_r <= '0;
    else if (cmd.mac) acc_r <= acc_r + term;
    if (cmd.finish) begin
      pred_r <= sat;
      err_r  <= err;
      hit_r  <= (err < Limit);
    end
  end

  logic [16:0] items_n, hits_n;
  always_comb begin
    items_n = items_r;
    hits_n  = hits_r;
    if (items_r < Cap) begin
      items_n = items_r + 17'd1;
      if (err < Limit) hits_n = hits_r + 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r  <= '0;
      hits_r  <= '0;
      items_r <= '0;
    end else if (cmd.finish) begin
      if (last_r) begin
        esum_r  <= '0;
        hits_r  <= '0;
        items_r <= '0;
      end else begin
        esum_r  <= esum_add[56] ? Max56 : esum_add[55:0];
        hits_r  <= hits_n;
        items_r <= items_n;
      end
    end
  end

  // totals including the current record, and the dividend, kept for the dividers
  logic [55:0] fin_sum_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      fin_sum_r   <= esum_add[56] ? Max56 : esum_add[55:0];
      fin_hits_r  <= hits_n;
      fin_items_r <= items_n;
    end
  end

  // remainders stay below the item count, so 17 bits hold them
  logic [17:0] mtry;
  logic [17:0] ftry;
  always_comb begin
    mtry = {mrem_r, mq_r[55]} - {1'b0, fin_items_r};
    ftry = {frem_r, fq_r[55]} - {1'b0, fin_items_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      mq_r   <= fin_sum_r;
      mrem_r <= '0;
      fq_r   <= {23'd0, fin_hits_r, 16'd0};
      frem_r <= '0;
    end else if (cmd.div_step) begin
      if (!mtry[17]) begin
        mrem_r <= mtry[16:0];
        mq_r   <= {mq_r[54:0], 1'b1};
      end else begin
        mrem_r <= {mrem_r[15:0], mq_r[55]};
        mq_r   <= {mq_r[54:0], 1'b0};
      end
      if (!ftry[17]) begin
        frem_r <= ftry[16:0];
        fq_r   <= {fq_r[54:0], 1'b1};
      end else begin
        frem_r <= {frem_r[15:0], fq_r[55]};
        fq_r   <= {fq_r[54:0], 1'b0};
      end
    end
  end

  // both dividers run 56 steps; the fraction dividend is zero-extended to match
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_predicted_price <= pred_r;
      out_abs_error       <= err_r;
      out_within_limit    <= hit_r;
      out_run_done        <= last_r;
      if (last_r && fin_items_r != 17'd0) begin
        out_mean_error        <= (mq_r > 56'(Max39)) ? Max39 : mq_r[38:0];
        out_hit_total         <= fin_hits_r;
        out_item_total        <= fin_items_r;
        out_accuracy_fraction <= fq_r[16:0];
      end else begin
        out_mean_error        <= '0;
        out_hit_total         <= last_r ? fin_hits_r : '0;
        out_item_total        <= last_r ? fin_items_r : '0;
        out_accuracy_fraction <= '0;
      end
    end
  end

endmodule

// ===== src/linear_model_predict_and_score.sv =====
// sequence: once a request is taken, the eight weighted terms are summed in turn,
// then the result is scored and loaded into the output register; on end of run
// the bit-serial mean and fraction dividers run between scoring and the output load
// input stalled while in work, so a new request is taken only when idle
// the output register lets the next record start while a result waits
// reset (rst_n low, synchronous) zeroes coefficients, error sum and counts
module linear_model_predict_and_score import lmps_pkg::*; #(
  parameter longint MAX_ITEMS   = 65536,
  parameter longint ERROR_LIMIT = 2560000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [39:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        in_size,
  input  logic [7:0]         in_location,
  input  logic [7:0]         in_security,
  input  logic [7:0]         in_garage,
  input  logic [7:0]         in_storey,
  input  logic [7:0]         in_room_count,
  input  logic [11:0]        in_build_year,
  input  logic signed [39:0] in_true_price,
  input  logic               in_end_of_run,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [39:0] out_predicted_price,
  output logic [38:0]        out_abs_error,
  output logic               out_within_limit,
  output logic               out_run_done,
  output logic [38:0]        out_mean_error,
  output logic [16:0]        out_hit_total,
  output logic [16:0]        out_item_total,
  output logic [16:0]        out_accuracy_fraction
);

  lmps_cmd_t cmd;
  lmps_sts_t sts;

  assign cfg_ready = 1'b1;

  lmps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  lmps_dp #(.MAX_ITEMS(MAX_ITEMS), .ERROR_LIMIT(ERROR_LIMIT)) u_dp (
    .clk, .rst_n,
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (signed'(cfg_data)),
    .in_take   (in_valid && !in_stall),
    .in_size, .in_location, .in_security, .in_garage, .in_storey,
    .in_room_count, .in_build_year, .in_true_price, .in_end_of_run,
    .cmd, .sts,
    .out_predicted_price, .out_abs_error, .out_within_limit, .out_run_done,
    .out_mean_error, .out_hit_total, .out_item_total, .out_accuracy_fraction
  );

endmodule

// ===== tb/linear_model_predict_and_score_tb.sv =====
// self-checking testbench for the linear model predictor and scorer
module linear_model_predict_and_score_tb;
  import lmps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ItemCap    = 65536;
  localparam longint ErrLimit   = 2560000;
  localparam int     CycleLimit = 600000;
  localparam logic [CfgIdxW-1:0] IdxSpare = 4'd8;
  localparam logic [CfgIdxW-1:0] IdxTop   = 4'hF;

  typedef struct packed {
    logic [23:0] size;
    logic [7:0]  location;
    logic [7:0]  security;
    logic [7:0]  garage;
    logic [7:0]  storey;
    logic [7:0]  room_count;
    logic [11:0] build_year;
    logic [39:0] true_price;
    logic        end_of_run;
  } record_t;

  typedef struct packed {
    logic [39:0] price;
    logic [38:0] abs_err;
    logic        hit;
    logic        done;
    logic [38:0] mean_err;
    logic [16:0] hits;
    logic [16:0] items;
    logic [16:0] frac;
  } score_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [39:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  record_t rec_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [39:0] out_predicted_price;
  logic [38:0] out_abs_error, out_mean_error;
  logic out_within_limit, out_run_done;
  logic [16:0] out_hit_total, out_item_total, out_accuracy_fraction;

  // model state
  longint coef [NumRegs];
  longint unsigned err_sum, hit_cnt, item_cnt;
  score_t pending_scores[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  sent = 0;
  int  runs_done = 0;
  int  hits_seen = 0;
  bit  calm = 0;
  bit  long_hold = 0;

  linear_model_predict_and_score dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_size(rec_q.size), .in_location(rec_q.location), .in_security(rec_q.security),
    .in_garage(rec_q.garage), .in_storey(rec_q.storey),
    .in_room_count(rec_q.room_count), .in_build_year(rec_q.build_year),
    .in_true_price(rec_q.true_price), .in_end_of_run(rec_q.end_of_run),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_predicted_price(out_predicted_price), .out_abs_error(out_abs_error),
    .out_within_limit(out_within_limit), .out_run_done(out_run_done),
    .out_mean_error(out_mean_error), .out_hit_total(out_hit_total),
    .out_item_total(out_item_total), .out_accuracy_fraction(out_accuracy_fraction)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [39:0] rand40();
    return {8'($urandom_range(255, 0)), $urandom()};
  endfunction

  // weighted sum of Q.8 coefficients (size weight Q.16), saturated to 40 bits
  function automatic longint price_of(record_t r);
    longint acc;
    acc = coef[0] >>> 8;
    acc += (coef[1] * longint'(r.size)) >>> 16;
    acc += (coef[2] * longint'(r.location)) >>> 8;
    acc += (coef[3] * longint'(r.security)) >>> 8;
    acc += (coef[4] * longint'(r.garage)) >>> 8;
    acc += (coef[5] * longint'(r.storey)) >>> 8;
    acc += (coef[6] * longint'(r.room_count)) >>> 8;
    acc += (coef[7] * longint'(r.build_year)) >>> 8;
    if (acc > longint'(Pos40)) acc = longint'(Pos40);
    if (acc < longint'(Neg40)) acc = longint'(Neg40);
    return acc;
  endfunction

  function automatic score_t score_record(record_t r);
    score_t s;
    longint acc, diff;
    longint unsigned err;
    acc = price_of(r);
    diff = acc - longint'($signed(r.true_price));
    err = (diff < 0) ? longint'(-diff) : diff;
    if (err > longint'(Max39)) err = longint'(Max39);
    s = '0;
    s.price = acc[39:0];
    s.abs_err = err[38:0];
    s.hit = (err < ErrLimit);
    s.done = r.end_of_run;
    err_sum += err;
    if (err_sum > longint'(Max56)) err_sum = longint'(Max56);
    if (item_cnt < ItemCap) begin
      item_cnt++;
      if (s.hit) hit_cnt++;
    end
    if (r.end_of_run) begin
      s.items = item_cnt[16:0];
      s.hits = hit_cnt[16:0];
      if (item_cnt != 0) begin
        s.mean_err = (err_sum / item_cnt > longint'(Max39)) ? Max39 : 39'(err_sum / item_cnt);
        s.frac = 17'((hit_cnt << 16) / item_cnt);
      end
      err_sum = 0;
      hit_cnt = 0;
      item_cnt = 0;
    end
    return s;
  endfunction

  // model follows the accepted requests
  always @(posedge clk) begin
    cycles++;
    if (!rst_n) begin
      foreach (coef[i]) coef[i] = 0;
      err_sum = 0;
      hit_cnt = 0;
      item_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NumRegs)
        coef[cfg_index[RegIdxW-1:0]] = longint'($signed(cfg_data));
      if (in_valid && !in_stall)
        pending_scores.push_back(score_record(rec_q));
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    score_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        report("unexpected result", 64'(out_predicted_price), 64'd0);
      end else begin
        want = pending_scores.pop_front();
        if (out_predicted_price !== want.price)
          report("predicted_price", 64'(out_predicted_price), 64'(want.price));
        if (out_abs_error !== want.abs_err)
          report("abs_error", 64'(out_abs_error), 64'(want.abs_err));
        if (out_within_limit !== want.hit)
          report("within_limit", 64'(out_within_limit), 64'(want.hit));
        if (out_run_done !== want.done)
          report("run_done", 64'(out_run_done), 64'(want.done));
        if (out_mean_error !== want.mean_err)
          report("mean_error", 64'(out_mean_error), 64'(want.mean_err));
        if (out_hit_total !== want.hits)
          report("hit_total", 64'(out_hit_total), 64'(want.hits));
        if (out_item_total !== want.items)
          report("item_total", 64'(out_item_total), 64'(want.items));
        if (out_accuracy_fraction !== want.frac)
          report("accuracy_fraction", 64'(out_accuracy_fraction), 64'(want.frac));
        if (want.done) runs_done++;
        if (want.hit) hits_seen++;
      end
    end
  end

  // receiver: random hold-off per result, or one long hold when asked
  always begin
    int n;
    @(posedge clk);
    if (long_hold) begin
      out_stall <= 1'b1;
      repeat (300) @(posedge clk);
      long_hold = 0;
      out_stall <= 1'b0;
    end else begin
      n = calm ? 0 : $urandom_range(3, 0);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [39:0] value);
    bit ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
      if (ready_seen) break;
    end
  endtask

  task automatic load_coefs(logic [39:0] c0, c1, c2, c3, c4, c5, c6, c7);
    wait_drained();
    write_reg(CfgIdxW'(RegIntercept), c0);
    write_reg(CfgIdxW'(RegWtSize), c1);
    write_reg(CfgIdxW'(RegWtLoc), c2);
    write_reg(CfgIdxW'(RegWtSec), c3);
    write_reg(CfgIdxW'(RegWtGar), c4);
    write_reg(CfgIdxW'(RegWtStorey), c5);
    write_reg(CfgIdxW'(RegWtRooms), c6);
    write_reg(CfgIdxW'(RegWtYear), c7);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_record(record_t r);
    int gap;
    bit stalled;
    gap = calm ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rec_q <= r;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    sent++;
  endtask

  function automatic record_t random_record(int run_len);
    record_t r;
    r.size = ($urandom_range(7, 0) == 0) ? 24'hFFFFFF : 24'($urandom());
    r.location = 8'($urandom());
    r.security = 8'($urandom());
    r.garage = 8'($urandom());
    r.storey = 8'($urandom());
    r.room_count = 8'($urandom());
    r.build_year = 12'($urandom());
    // mostly near the prediction so that hits and misses both occur
    case ($urandom_range(3, 0))
      0: r.true_price = rand40();
      1: r.true_price = 40'(price_of(r) + longint'($urandom_range(5000000, 0)) - 2500000);
      default: r.true_price = 40'(price_of(r) + longint'($urandom_range(4000, 0)) - 2000);
    endcase
    r.end_of_run = ($urandom_range(run_len, 1) == 1);
    return r;
  endfunction

  function automatic record_t fixed_record(logic [23:0] sz, logic [7:0] f8, logic [11:0] yr,
                                           logic [39:0] truth, logic last);
    record_t r;
    r = '{sz, f8, f8, f8, f8, f8, yr, truth, last};
    return r;
  endfunction

  task automatic test_reset_values();
    send_record(fixed_record(24'hFFFFFF, 8'hFF, 12'hFFF, 40'd0, 1'b0));
    send_record(fixed_record(24'd0, 8'd0, 12'd0, 40'h7FFFFFFFFF, 1'b0));
    send_record(fixed_record(24'd1, 8'd1, 12'd1, 40'h8000000000, 1'b1));
  endtask

  task automatic test_extremes();
    // largest positive coefficients, then the most negative, to hit both clamps
    load_coefs(40'h7FFFFFFFFF, 40'h7FFFFFFFFF, 40'h7FFFFFFFFF, 40'h7FFFFFFFFF,
               40'h7FFFFFFFFF, 40'h7FFFFFFFFF, 40'h7FFFFFFFFF, 40'h7FFFFFFFFF);
    send_record(fixed_record(24'hFFFFFF, 8'hFF, 12'hFFF, 40'h8000000000, 1'b0));
    send_record(fixed_record(24'd0, 8'd0, 12'd0, 40'h7FFFFFFFFF, 1'b0));
    send_record(fixed_record(24'hFFFFFF, 8'hFF, 12'hFFF, 40'h7FFFFFFFFF, 1'b1));
    load_coefs(40'h8000000000, 40'h8000000000, 40'h8000000000, 40'h8000000000,
               40'h8000000000, 40'h8000000000, 40'h8000000000, 40'h8000000000);
    send_record(fixed_record(24'hFFFFFF, 8'hFF, 12'hFFF, 40'h7FFFFFFFFF, 1'b0));
    send_record(fixed_record(24'd1, 8'd1, 12'd1, 40'h8000000000, 1'b0));
    // odd negative products check the round-down shift
    load_coefs(40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 40'hFFFFFFFF01, 40'hFFFFFFFFFF,
               40'h0000000001, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF);
    send_record(fixed_record(24'd3, 8'd3, 12'd3, 40'd0, 1'b0));
    send_record(fixed_record(24'd1, 8'd1, 12'd1, 40'd0, 1'b1));
  endtask

  task automatic test_unknown_index();
    wait_drained();
    write_reg(IdxSpare, 40'h1234567890);
    write_reg(IdxTop, 40'hFFFFFFFFFF);
    cfg_valid <= 1'b0;
    send_record(fixed_record(24'h000100, 8'd2, 12'd2000, 40'd0, 1'b1));
  endtask

  task automatic test_error_limit();
    // zero model: prediction 0, so the true price sets the error directly
    load_coefs(40'd0, 40'd0, 40'd0, 40'd0, 40'd0, 40'd0, 40'd0, 40'd0);
    send_record(fixed_record(24'd5, 8'd5, 12'd5, 40'(ErrLimit - 1), 1'b0));
    send_record(fixed_record(24'd5, 8'd5, 12'd5, 40'(ErrLimit), 1'b0));
    send_record(fixed_record(24'd5, 8'd5, 12'd5, 40'(-(ErrLimit - 1)), 1'b0));
    send_record(fixed_record(24'd5, 8'd5, 12'd5, 40'(-ErrLimit), 1'b1));
    // lone record run
    send_record(fixed_record(24'd5, 8'd5, 12'd5, 40'd0, 1'b1));
  endtask

  task automatic test_random_phases();
    int run_len;
    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase == 3);
      if (phase % 2 == 0)
        load_coefs(40'($signed(rand40()) >>> 8), 40'($urandom_range(65535, 0) << 12),
                   40'($urandom() - 32'h8000_0000), 40'($urandom()), 40'($urandom_range(9999, 0)),
                   40'($signed(rand40()) >>> 4), 40'($urandom_range(1000000, 0)),
                   40'($urandom_range(70000, 0)));
      else
        load_coefs(rand40(), rand40(), rand40(), rand40(),
                   rand40(), rand40(), rand40(), rand40());
      run_len = (phase == 5) ? 200 : $urandom_range(30, 2);
      repeat (105) send_record(random_record(run_len));
      send_record(fixed_record(24'd0, 8'd0, 12'd0, 40'd0, 1'b1));
    end
    calm = 0;
  endtask

  task automatic test_back_pressure();
    long_hold = 1;
    repeat (30) send_record(random_record(10));
    send_record(fixed_record(24'd7, 8'd7, 12'd7, 40'd7, 1'b1));
    // sender waits for every result before going on
    wait_drained();
    repeat (20) send_record(random_record(6));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_unknown_index();
    test_error_limit();
    test_random_phases();
    test_back_pressure();
    wait_drained();
    $display("%0d records sent, %0d runs closed, %0d results within the limit",
             sent, runs_done, hits_seen);
    $display("covered coefficient extremes, clamps, limit edges, unknown indexes and stalls");
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
